// ===== hdl/lbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and helpers for the skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

   localparam int PALETTE_SIZE   = 16;
   localparam int MAX_WEIGHTS    = 4;
   localparam int ELEMS_PER_BONE = 12;
   localparam int PAL_DEPTH      = PALETTE_SIZE * ELEMS_PER_BONE;
   localparam int PAL_AW         = $clog2(PAL_DEPTH);
   localparam int ELEM_TRANS     = 9;

   localparam logic       CMD_LOAD   = 1'b0;
   localparam logic       CMD_VERTEX = 1'b1;
   localparam logic [1:0] CSR_WPV    = 2'd0;
   localparam logic [1:0] CSR_SKIN   = 2'd1;

   typedef struct packed {
      logic               command;
      logic               load_ok;
      logic [3:0]         slot;
      logic [3:0]         elem;
      logic signed [31:0] value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        indices;
      logic [63:0]        weights;
   } item_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== hdl/lbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_front
// Accepts items, classifies loads and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lbs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [3:0]            req_matrix_slot,
   input  logic [3:0]            req_matrix_element,
   input  logic signed [31:0]    req_matrix_value,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   input  logic signed [31:0]    req_pos_z,
   input  logic [15:0]           req_bone_indices,
   input  logic [63:0]           req_bone_weights,
   output logic                  q_valid,
   output lbs_pkg::item_type     q_item,
   input  logic                  q_pop
);

   lbs_pkg::item_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic       push;
   lbs_pkg::item_type new_item;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rptr_ff];

   always_comb begin
      new_item.command = req_command;
      new_item.load_ok = (32'(req_matrix_slot) < lbs_pkg::PALETTE_SIZE) &&
                         (32'(req_matrix_element) < lbs_pkg::ELEMS_PER_BONE);
      new_item.slot    = req_matrix_slot;
      new_item.elem    = req_matrix_element;
      new_item.value   = req_matrix_value;
      new_item.pos_x   = req_pos_x;
      new_item.pos_y   = req_pos_y;
      new_item.pos_z   = req_pos_z;
      new_item.indices = req_bone_indices;
      new_item.weights = req_bone_weights;
   end

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ q_pop;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= new_item;
      end
   end

endmodule

// ===== hdl/lbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_back
// Palette memory, transform and blend sequencer, config and result register.
// ----------------------------------------------------------------------------
module lbs_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  lbs_pkg::item_type     q_item,
   output logic                  q_pop,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_out_x,
   output logic signed [31:0]    rsp_out_y,
   output logic signed [31:0]    rsp_out_z
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PAIR  = 4'd1;
   localparam logic [3:0] S_ROW   = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_ACC   = 4'd5;
   localparam logic [3:0] S_BMUL  = 4'd6;
   localparam logic [3:0] S_BACC  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   localparam int PAL_AW_L = lbs_pkg::PAL_AW;

   logic [31:0] pal_mem [lbs_pkg::PAL_DEPTH];
   logic signed [31:0] rdata_ff;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  wpv_ff, wpv_in;
   logic        skin_ff, skin_in;
   logic [2:0]  count_ff, count_in;
   logic [2:0]  k_ff, k_in;
   logic [1:0]  r_ff, r_in;
   logic [1:0]  e_ff, e_in;
   lbs_pkg::item_type cur_ff, cur_in;
   logic signed [63:0] t_ff, t_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] bprod_ff, bprod_in;
   logic signed [63:0] acc_ff [3];
   logic signed [63:0] acc_in [3];
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_ff [3];
   logic signed [31:0] out_in [3];

   logic [3:0]  bone;
   logic [15:0] wgt;
   logic signed [31:0] pos_e, pos_r, tsat;
   logic [PAL_AW_L-1:0] raddr;
   logic [PAL_AW_L-1:0] waddr;
   logic        rd_en, wr_en;
   logic [3:0]  elem_sel;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

   always_comb begin
      bone = cur_ff.indices[k_ff[1:0]*4 +: 4];
      wgt  = cur_ff.weights[k_ff[1:0]*16 +: 16];
      case (e_ff)
         2'd0:    pos_e = cur_ff.pos_x;
         2'd1:    pos_e = cur_ff.pos_y;
         default: pos_e = cur_ff.pos_z;
      endcase
      case (r_ff)
         2'd0:    pos_r = cur_ff.pos_x;
         2'd1:    pos_r = cur_ff.pos_y;
         default: pos_r = cur_ff.pos_z;
      endcase
      if (e_ff == 2'd3) begin
         elem_sel = 4'(lbs_pkg::ELEM_TRANS) + {2'b00, r_ff};
      end else begin
         elem_sel = {1'b0, r_ff, 1'b0} + {2'b00, r_ff} + {2'b00, e_ff};
      end
      raddr = PAL_AW_L'({bone, 3'b000}) + PAL_AW_L'({bone, 2'b00}) + PAL_AW_L'(elem_sel);
      waddr = PAL_AW_L'({q_item.slot, 3'b000}) + PAL_AW_L'({q_item.slot, 2'b00}) +
              PAL_AW_L'(q_item.elem);
      tsat  = skin_ff ? lbs_pkg::sat32(t_ff) : pos_r;
   end

   always_comb begin
      state_in     = state_ff;
      wpv_in       = wpv_ff;
      skin_in      = skin_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      e_in         = e_ff;
      cur_in       = cur_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      bprod_in     = bprod_ff;
      acc_in       = acc_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      if (csr_valid) begin
         if (csr_index == lbs_pkg::CSR_WPV) begin
            wpv_in = csr_data[2:0];
         end else if (csr_index == lbs_pkg::CSR_SKIN) begin
            skin_in = csr_data[0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               if (q_item.command == lbs_pkg::CMD_LOAD) begin
                  wr_en = q_item.load_ok;
               end else begin
                  count_in  = (32'(wpv_ff) > lbs_pkg::MAX_WEIGHTS) ?
                              3'(lbs_pkg::MAX_WEIGHTS) : wpv_ff;
                  k_in      = 3'd0;
                  acc_in[0] = 64'sd0;
                  acc_in[1] = 64'sd0;
                  acc_in[2] = 64'sd0;
                  state_in  = S_PAIR;
               end
            end
         end
         S_PAIR: begin
            if (k_ff == count_ff) begin
               state_in = S_OUT;
            end else if (wgt == 16'd0 || 32'(bone) >= lbs_pkg::PALETTE_SIZE) begin
               k_in = k_ff + 3'd1;
            end else begin
               r_in     = 2'd0;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            e_in     = 2'd0;
            t_in     = 64'sd0;
            state_in = skin_ff ? S_RD : S_BMUL;
         end
         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (e_ff == 2'd3) begin
               prod_in = {{16{rdata_ff[31]}}, rdata_ff, 16'h0000};
            end else begin
               prod_in = rdata_ff * pos_e;
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            t_in = t_ff + (prod_ff >>> 16);
            e_in = e_ff + 2'd1;
            state_in = (e_ff == 2'd3) ? S_BMUL : S_RD;
         end
         S_BMUL: begin
            bprod_in = tsat * $signed({1'b0, wgt});
            state_in = S_BACC;
         end
         S_BACC: begin
            acc_in[r_ff] = acc_ff[r_ff] + bprod_ff;
            if (r_ff == 2'd2) begin
               k_in     = k_ff + 3'd1;
               state_in = S_PAIR;
            end else begin
               r_in     = r_ff + 2'd1;
               state_in = S_ROW;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in[0]    = lbs_pkg::sat32(acc_ff[0] >>> 15);
               out_in[1]    = lbs_pkg::sat32(acc_ff[1] >>> 15);
               out_in[2]    = lbs_pkg::sat32(acc_ff[2] >>> 15);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wpv_ff       <= 3'd4;
         skin_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpv_ff       <= wpv_in;
         skin_ff      <= skin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      e_ff     <= e_in;
      cur_ff   <= cur_in;
      t_ff     <= t_in;
      prod_ff  <= prod_in;
      bprod_ff <= bprod_in;
      acc_ff   <= acc_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pal_mem[waddr] <= q_item.value;
      end
      if (rd_en) begin
         rdata_ff <= pal_mem[raddr];
      end
   end

endmodule

// ===== hdl/linear_blend_skinning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Sequence: a load item is registered in the queue, then written to the palette
// when the back end pops it. A vertex item steps through its weight pairs; when
// skinning, each used pair goes through the palette read port one element at a
// time, and in identity mode it blends the position directly; unused pairs are skipped.
// Throughput: one item at a time in the back end, two more wait in the queue.
// Reset: synchronous; clears queue and result valid, four weights, skinning on.
// ----------------------------------------------------------------------------
module linear_blend_skinning (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic [3:0]         req_matrix_slot,
   input  logic [3:0]         req_matrix_element,
   input  logic signed [31:0] req_matrix_value,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_bone_indices,
   input  logic [63:0]        req_bone_weights,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z
);

   logic              q_valid;
   logic              q_pop;
   lbs_pkg::item_type q_item;

   lbs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_matrix_slot    (req_matrix_slot),
      .req_matrix_element (req_matrix_element),
      .req_matrix_value   (req_matrix_value),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pos_z          (req_pos_z),
      .req_bone_indices   (req_bone_indices),
      .req_bone_weights   (req_bone_weights),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   lbs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .rsp_out_z (rsp_out_z)
   );

endmodule

// ===== hdl/lbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks on the skinning block, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               csr_ready,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_x) && $stable(rsp_out_y) &&
      $stable(rsp_out_z))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port not ready");

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .csr_ready (csr_ready),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_out_x (rsp_out_x),
   .rsp_out_y (rsp_out_y),
   .rsp_out_z (rsp_out_z)
);
